// ===== rtl/positional_list_engine_assert.svh =====
// Assertion macros shared by the positional list engine RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ple_pkg.sv =====
// Types and codes for the positional list engine.
// Used by positional_list_engine; no dependencies.
package ple_pkg;

  localparam int POS_W   = 6;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;

  typedef enum logic [2:0] {
    ACT_APPEND    = 3'd0,
    ACT_PREPEND   = 3'd1,
    ACT_INSERT_AT = 3'd2,
    ACT_DEL_LAST  = 3'd3,
    ACT_DEL_AT    = 3'd4,
    ACT_UPDATE_AT = 3'd5,
    ACT_SORT      = 3'd6,
    ACT_TRAVERSE  = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_MV,
    S_DEL_RD,
    S_DEL_MV,
    S_UPD,
    S_SRT_START,
    S_SRT_LD0,
    S_SRT_RD,
    S_SRT_CMP,
    S_TRV_RD,
    S_TRV_OUT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [2:0]                action;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] data_value;
    logic                      has_data;
    logic                      last;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        element_count;
  } rsp_t;

endpackage

// ===== rtl/positional_list_engine.sv =====
// Positional list engine: ordered list of signed values in one RAM, edited
// by a small sequencer with a single read/write port pair and one comparator.
// Depends on ple_pkg, ple_ram and positional_list_engine_assert.svh.
//
//  channel | signals                   | direction | meaning
//  --------+---------------------------+-----------+-------------------------
//  request | req_valid, req_stall, req | in        | one list action
//  result  | rsp_valid, rsp_stall, rsp | out       | status or traversed item
//
// Steps after accept (n = element count): update is one write; insert and
// delete shift the tail by a read and a write per element; sort runs n-1
// bubble passes; traverse reads and then outputs each element in turn.
// All element moves go through the one RAM port pair.
// Reset clears the count and sequencer; the RAM contents are not cleared.
// req_stall is high while an action runs; a stalled result holds the
// sequencer in place until the result register frees up.
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ple_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ple_pkg::rsp_t  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

  ple_pkg::state_t  state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    pos, pos_next;
  logic [CW-1:0]    idx, idx_next;
  logic [CW-1:0]    pass, pass_next;
  logic [31:0]      val, val_next;
  logic [31:0]      carry, carry_next;
  ple_pkg::status_t status, status_next;
  ple_pkg::rsp_t    rsp_next;
  logic             rsp_valid_next;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [31:0]      wdata, rdata;

  logic [PW-1:0]    cnt_w, pos_w, ins_pos_w;
  logic             out_free;
  logic             ins_bad, list_full, pos_bad, trv_last;

  assign req_stall = (state != ple_pkg::S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign cnt_w     = PW'(count);
  assign pos_w     = PW'(req.position);
  always_comb begin
    case (ple_pkg::act_t'(req.action))
      ple_pkg::ACT_APPEND:  ins_pos_w = cnt_w;
      ple_pkg::ACT_PREPEND: ins_pos_w = '0;
      default:              ins_pos_w = pos_w;
    endcase
  end
  assign ins_bad   = (ins_pos_w > cnt_w);
  assign list_full = (count >= CW'(CAPACITY));
  assign pos_bad   = (pos_w >= cnt_w);
  assign trv_last  = (CW'(idx + 1'b1) == count);

  ple_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ple_pkg::S_IDLE: begin
        if (req_valid) begin
          unique case (ple_pkg::act_t'(req.action))
            ple_pkg::ACT_APPEND, ple_pkg::ACT_PREPEND, ple_pkg::ACT_INSERT_AT:
              state_next = (ins_bad || list_full) ? ple_pkg::S_RESULT
                                                  : ple_pkg::S_INS_RD;
            ple_pkg::ACT_DEL_LAST:
              state_next = (count == '0) ? ple_pkg::S_RESULT : ple_pkg::S_DEL_RD;
            ple_pkg::ACT_DEL_AT:
              state_next = pos_bad ? ple_pkg::S_RESULT : ple_pkg::S_DEL_RD;
            ple_pkg::ACT_UPDATE_AT:
              state_next = pos_bad ? ple_pkg::S_RESULT : ple_pkg::S_UPD;
            ple_pkg::ACT_SORT:
              state_next = (count == '0) ? ple_pkg::S_RESULT : ple_pkg::S_SRT_START;
            ple_pkg::ACT_TRAVERSE:
              state_next = (count == '0) ? ple_pkg::S_RESULT : ple_pkg::S_TRV_RD;
            default: state_next = ple_pkg::S_RESULT;
          endcase
        end
      end
      ple_pkg::S_INS_RD:
        state_next = (idx > pos) ? ple_pkg::S_INS_MV : ple_pkg::S_RESULT;
      ple_pkg::S_INS_MV:  state_next = ple_pkg::S_INS_RD;
      ple_pkg::S_DEL_RD:
        state_next = (CW'(idx + 1'b1) < count) ? ple_pkg::S_DEL_MV : ple_pkg::S_RESULT;
      ple_pkg::S_DEL_MV:  state_next = ple_pkg::S_DEL_RD;
      ple_pkg::S_UPD:     state_next = ple_pkg::S_RESULT;
      ple_pkg::S_SRT_START:
        state_next = (CW'(pass + 1'b1) < count) ? ple_pkg::S_SRT_LD0 : ple_pkg::S_RESULT;
      ple_pkg::S_SRT_LD0: state_next = ple_pkg::S_SRT_RD;
      ple_pkg::S_SRT_RD:
        state_next = (idx < count) ? ple_pkg::S_SRT_CMP : ple_pkg::S_SRT_START;
      ple_pkg::S_SRT_CMP: state_next = ple_pkg::S_SRT_RD;
      ple_pkg::S_TRV_RD:  state_next = ple_pkg::S_TRV_OUT;
      ple_pkg::S_TRV_OUT: begin
        if (out_free) begin
          state_next = trv_last ? ple_pkg::S_IDLE : ple_pkg::S_TRV_RD;
        end
      end
      ple_pkg::S_RESULT: begin
        if (out_free) begin
          state_next = ple_pkg::S_IDLE;
        end
      end
      default: state_next = ple_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    we             = 1'b0;
    re             = 1'b0;
    waddr          = idx[AW-1:0];
    raddr          = idx[AW-1:0];
    wdata          = rdata;
    count_next     = count;
    pos_next       = pos;
    idx_next       = idx;
    pass_next      = pass;
    val_next       = val;
    carry_next     = carry;
    status_next    = status;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;

    unique case (state)
      ple_pkg::S_IDLE: begin
        if (req_valid) begin
          val_next    = req.value;
          pass_next   = '0;
          status_next = ple_pkg::ST_DONE;
          unique case (ple_pkg::act_t'(req.action))
            ple_pkg::ACT_APPEND, ple_pkg::ACT_PREPEND, ple_pkg::ACT_INSERT_AT: begin
              // out-of-range position wins over full
              if (ins_bad) begin
                status_next = ple_pkg::ST_IGNORED;
              end else if (list_full) begin
                status_next = ple_pkg::ST_FULL;
              end
              pos_next = CW'(ins_pos_w);
              idx_next = count;
            end
            ple_pkg::ACT_DEL_LAST: begin
              if (count == '0) begin
                status_next = ple_pkg::ST_IGNORED;
              end
              idx_next = count - 1'b1;
            end
            ple_pkg::ACT_DEL_AT, ple_pkg::ACT_UPDATE_AT: begin
              if (pos_bad) begin
                status_next = ple_pkg::ST_IGNORED;
              end
              pos_next = CW'(pos_w);
              idx_next = CW'(pos_w);
            end
            ple_pkg::ACT_SORT: begin
              if (count == '0) begin
                status_next = ple_pkg::ST_IGNORED;
              end
            end
            ple_pkg::ACT_TRAVERSE: idx_next = '0;
            default: ;
          endcase
        end
      end
      ple_pkg::S_INS_RD: begin
        if (idx > pos) begin
          re    = 1'b1;
          raddr = AW'(idx - 1'b1);
        end else begin
          we         = 1'b1;
          waddr      = pos[AW-1:0];
          wdata      = val;
          count_next = count + 1'b1;
        end
      end
      ple_pkg::S_INS_MV: begin
        we       = 1'b1;
        idx_next = idx - 1'b1;
      end
      ple_pkg::S_DEL_RD: begin
        if (CW'(idx + 1'b1) < count) begin
          re    = 1'b1;
          raddr = AW'(idx + 1'b1);
        end else begin
          count_next = count - 1'b1;
        end
      end
      ple_pkg::S_DEL_MV: begin
        we       = 1'b1;
        idx_next = idx + 1'b1;
      end
      ple_pkg::S_UPD: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
        wdata = val;
      end
      ple_pkg::S_SRT_START: begin
        // each pass carries the running maximum toward the tail
        re       = 1'b1;
        raddr    = '0;
        idx_next = CW'(1);
      end
      ple_pkg::S_SRT_LD0: carry_next = rdata;
      ple_pkg::S_SRT_RD: begin
        if (idx < count) begin
          re = 1'b1;
        end else begin
          we        = 1'b1;
          waddr     = AW'(count - 1'b1);
          wdata     = carry;
          pass_next = pass + 1'b1;
        end
      end
      ple_pkg::S_SRT_CMP: begin
        we       = 1'b1;
        waddr    = AW'(idx - 1'b1);
        idx_next = idx + 1'b1;
        if ($signed(carry) > $signed(rdata)) begin
          wdata = rdata;
        end else begin
          wdata      = carry;
          carry_next = rdata;
        end
      end
      ple_pkg::S_TRV_RD: re = 1'b1;
      ple_pkg::S_TRV_OUT: begin
        if (out_free) begin
          rsp_valid_next         = 1'b1;
          rsp_next.data_value    = rdata;
          rsp_next.has_data      = 1'b1;
          rsp_next.last          = trv_last;
          rsp_next.status        = ple_pkg::ST_DONE;
          rsp_next.element_count = ple_pkg::COUNT_W'(count);
          idx_next               = idx + 1'b1;
        end
      end
      ple_pkg::S_RESULT: begin
        if (out_free) begin
          rsp_valid_next         = 1'b1;
          rsp_next.data_value    = '0;
          rsp_next.has_data      = 1'b0;
          rsp_next.last          = 1'b1;
          rsp_next.status        = status;
          rsp_next.element_count = ple_pkg::COUNT_W'(count);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ple_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    idx    <= idx_next;
    pass   <= pass_next;
    val    <= val_next;
    carry  <= carry_next;
    status <= status_next;
    rsp    <= rsp_next;
  end

  `PLE_ASSERT(a_count_cap, 1'b1, count <= CW'(CAPACITY), "count above capacity")

  `PLE_ASSERT(a_count_step, !$past(rst),
    count == $past(count) || count == CW'($past(count) + 1'b1) ||
    CW'(count + 1'b1) == $past(count), "count moved by more than one")

  `PLE_ASSERT(a_mid_has_data, rsp_valid && !rsp.last, rsp.has_data,
    "non-final result without element")

  `PLE_ASSERT(a_full_count, rsp_valid && rsp.status == ple_pkg::ST_FULL,
    rsp.element_count == ple_pkg::COUNT_W'(CAPACITY), "full reported below capacity")

endmodule

// ===== rtl/ple_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
